/* design/prf_pkg.sv */
`default_nettype none

package prf_pkg;

  // Built store depth and stored page width
  localparam int MAX_ENTRIES = 512;
  localparam int PAGE_BITS   = 20;

  // Fixed port field widths
  localparam int PAGE_W = 20;
  localparam int CAP_W  = 10;

  // Derived widths
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WIDE_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Reset values of the configuration registers
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

  // Configuration register indexes
  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // Policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

endpackage

`default_nettype wire

/* design/prf_ram.sv */
`default_nettype none

module prf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/page_replacement_fifo_lru_top.sv */
`default_nettype none

// Fully associative page store with FIFO or LRU replacement.
// Input channel: in_valid/in_stall carries one page_number word. Output
// channel: out_valid/out_stall carries one result word per input: hit,
// evicted_valid and evicted_page (zero unless a page was evicted).
// Configuration: wr_en/wr_index/wr_data; index 0 selects the policy
// (0 FIFO, 1 LRU), index 1 the capacity (0 acts as 1, values above the
// store depth act as the depth). Write only while the block is idle.
// Sequence: a lookup scans the tag and rank memories of the resident pages,
// one entry per cycle. A miss into a non-empty store or an LRU hit then
// rewrites every resident age rank through the rank memory's single write
// port, a miss then takes the insert step, and the finish step loads the
// output register.
// in_stall is high from acceptance until the result is loaded; a result
// waiting in the output register does not block the next input, but a
// second finished result holds until the first word is taken.
// Reset (rst, synchronous) empties the store, sets FIFO mode and a capacity
// of 64; no memory clearing pass is needed.
module page_replacement_fifo_lru_top
  import prf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic              wr_index,
  input  wire logic [CAP_W-1:0]  wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PAGE_W-1:0] page_number,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   hit,
  output logic                   evicted_valid,
  output logic      [PAGE_W-1:0] evicted_page
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_UPD  = 5'b00100,
    S_INS  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                 state;
  logic                   policy;
  logic [CAP_W-1:0]       capacity;
  logic [OCC_W-1:0]       occ;
  logic [PAGE_BITS-1:0]   page;
  logic [OCC_W-1:0]       rd_idx;
  logic                   pipe_v;
  logic [IDX_W-1:0]       pipe_idx;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       hit_rank;
  logic [IDX_W-1:0]       old_idx;
  logic [PAGE_BITS-1:0]   old_tag;
  logic                   evict;
  logic [IDX_W-1:0]       slot;

  logic [PAGE_BITS-1:0]   tag_rd;
  logic [IDX_W-1:0]       rank_rd;
  logic                   rank_we;
  logic [IDX_W-1:0]       rank_waddr;
  logic [IDX_W-1:0]       rank_wdata;
  logic                   tag_we;
  logic [OCC_W-1:0]       eff_cap;
  logic [WIDE_W-1:0]      cap_wide;
  logic                   issue;
  logic                   pass_done;
  logic                   out_free;
  logic [IDX_W-1:0]       rank_upd;

  // Clamp the configured capacity into 1..MAX_ENTRIES
  assign cap_wide = WIDE_W'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = OCC_W'(1);
    end else if (cap_wide > WIDE_W'(MAX_ENTRIES)) begin
      eff_cap = OCC_W'(MAX_ENTRIES);
    end else begin
      eff_cap = OCC_W'(cap_wide);
    end
  end

  assign issue     = (rd_idx < occ);
  assign pass_done = !issue && !pipe_v;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // New age rank for one entry during the update pass
  always_comb begin
    if (found) begin
      if (pipe_idx == hit_idx) begin
        rank_upd = '0;
      end else if (rank_rd < hit_rank) begin
        rank_upd = rank_rd + 1'b1;
      end else begin
        rank_upd = rank_rd;
      end
    end else begin
      rank_upd = rank_rd + 1'b1;
    end
  end

  // Steer the rank memory write port
  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = pipe_idx;
    rank_wdata = rank_upd;
    if (state == S_UPD) begin
      rank_we = pipe_v;
    end else if (state == S_INS) begin
      rank_we    = 1'b1;
      rank_waddr = slot;
      rank_wdata = '0;
    end
  end

  assign tag_we = (state == S_INS);

  prf_ram #(
    .WIDTH(PAGE_BITS),
    .DEPTH(MAX_ENTRIES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(slot),
    .wdata(page),
    .raddr(rd_idx[IDX_W-1:0]),
    .rdata(tag_rd)
  );

  prf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_ENTRIES)
  ) u_rank_ram (
    .clk  (clk),
    .we   (rank_we),
    .waddr(rank_waddr),
    .wdata(rank_wdata),
    .raddr(rd_idx[IDX_W-1:0]),
    .rdata(rank_rd)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= POLICY_FIFO;
      capacity <= CAPACITY_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_POLICY:   policy   <= wr_data[0];
        REG_CAPACITY: capacity <= wr_data;
        default:      ;
      endcase
    end
  end

  // Sequence scan, rank update, insert and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      occ    <= '0;
      rd_idx <= '0;
      pipe_v <= 1'b0;
      found  <= 1'b0;
      evict  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            page   <= PAGE_BITS'(page_number);
            rd_idx <= '0;
            pipe_v <= 1'b0;
            found  <= 1'b0;
            evict  <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read per cycle, compare the word read last cycle
          pipe_v   <= issue;
          pipe_idx <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (pipe_v) begin
            if (!found && tag_rd == page) begin
              found    <= 1'b1;
              hit_idx  <= pipe_idx;
              hit_rank <= rank_rd;
            end
            if (rank_rd == IDX_W'(occ - 1'b1)) begin
              old_idx <= pipe_idx;
              old_tag <= tag_rd;
            end
          end
          if (pass_done) begin
            rd_idx <= '0;
            evict  <= !found && (occ >= eff_cap);
            slot   <= (!found && (occ >= eff_cap)) ? old_idx : occ[IDX_W-1:0];
            if (found) begin
              state <= (policy == POLICY_LRU) ? S_UPD : S_FIN;
            end else begin
              state <= (occ == '0) ? S_INS : S_UPD;
            end
          end
        end
        S_UPD: begin
          // read-modify-write every resident rank
          pipe_v   <= issue;
          pipe_idx <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (pass_done) begin
            state <= found ? S_FIN : S_INS;
          end
        end
        S_INS: begin
          if (!evict) begin
            occ <= occ + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      hit           <= found;
      evicted_valid <= evict;
      evicted_page  <= evict ? PAGE_W'(old_tag) : '0;
    end
  end

  // Checks
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SCAN))
    else $error("accepted word did not start a scan");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(MAX_ENTRIES))
    else $error("occupancy beyond store depth");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (occ != $past(occ) && !$past(rst)) |-> ($past(state) == S_INS && occ == $past(occ) + 1'b1))
    else $error("occupancy changed outside an insert");

  a_rose_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside the finish step");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted_valid) |-> !hit)
    else $error("eviction reported on a hit");

endmodule

`default_nettype wire
